### sv/vgtq_pkg.sv
// ----------------------------------------------------------------------------
// vgtq_pkg
// Shared types and constants of the vsync grid timestamp quantizer.
// ----------------------------------------------------------------------------
package vgtq_pkg;

  localparam int unsigned TIME_BITS_DEF = 64;
  localparam int unsigned TS_W          = 64;
  localparam int unsigned ERR_W         = 48;
  localparam int unsigned IV_W          = 32;
  localparam int unsigned ADDR_W        = 3;
  localparam int unsigned OUT_DATA_W    = 2 * TS_W + ERR_W;

  // Reset interval: one period of a 120 Hz refresh.
  localparam logic [IV_W-1:0] INTERVAL_RESET = IV_W'(64'd1000000000000 / 64'd120000);

  // Register index, taken from paddr[2].
  localparam logic REG_INTERVAL = 1'b0;

  // Sequencer commands to the datapath.
  typedef struct packed {
    logic capture;
    logic div_step;
    logic round;
    logic clamp;
    logic mul_lo;
    logic add_lo;
    logic mul_hi;
    logic add_hi;
    logic err_sub;
    logic load_out;
  } vgtq_cmd_t;

  // Datapath status back to the sequencer.
  typedef struct packed {
    logic started;
  } vgtq_status_t;

endpackage

### sv/vgtq_ctrl.sv
// ----------------------------------------------------------------------------
// vgtq_ctrl
// Sequencer: steps one word through divide, round, clamp, multiply, error.
// ----------------------------------------------------------------------------
module vgtq_ctrl import vgtq_pkg::*; #(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  vgtq_status_t status,
  output vgtq_cmd_t    cmd
);

  localparam int unsigned CW = $clog2(TIME_BITS);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_ROUND, S_CLAMP, S_MUL_LO, S_ADD_LO,
    S_MUL_HI, S_ADD_HI, S_ERR, S_HOLD
  } state_t;

  state_t        state;
  logic [CW-1:0] cnt;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.capture  = (state == S_IDLE) && in_valid;
    cmd.div_step = (state == S_DIV);
    cmd.round    = (state == S_ROUND);
    cmd.clamp    = (state == S_CLAMP);
    cmd.mul_lo   = (state == S_MUL_LO);
    cmd.add_lo   = (state == S_ADD_LO);
    cmd.mul_hi   = (state == S_MUL_HI);
    cmd.add_hi   = (state == S_ADD_HI);
    cmd.err_sub  = (state == S_ERR);
    cmd.load_out = (state == S_HOLD) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            // anchor word bypasses the arithmetic
            state <= status.started ? S_DIV : S_HOLD;
            cnt   <= CW'(TIME_BITS - 1);
          end
        end
        S_DIV: begin
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= S_ROUND;
          end
        end
        S_ROUND:  state <= S_CLAMP;
        S_CLAMP:  state <= S_MUL_LO;
        S_MUL_LO: state <= S_ADD_LO;
        S_ADD_LO: state <= S_MUL_HI;
        S_MUL_HI: state <= S_ADD_HI;
        S_ADD_HI: state <= S_ERR;
        S_ERR:    state <= S_HOLD;
        S_HOLD: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default:  state <= S_IDLE;
      endcase
      // raise valid on load, drop it once the word is taken
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### sv/vgtq_dp.sv
// ----------------------------------------------------------------------------
// vgtq_dp
// Datapath: epoch state, restoring divider, split multiplier, error saturation.
// ----------------------------------------------------------------------------
module vgtq_dp import vgtq_pkg::*; #(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  vgtq_cmd_t        cmd,
  output vgtq_status_t     status,
  input  logic [IV_W-1:0]  interval,
  input  logic [TS_W-1:0]  timestamp,
  output logic [TS_W-1:0]  present_out,
  output logic [TS_W-1:0]  tick_out,
  output logic [ERR_W-1:0] error_out,
  output logic             anchored_out
);

  localparam int unsigned T = TIME_BITS;

  // state
  logic           started;
  logic [T-1:0]   epoch;
  logic [T-1:0]   prev_tick;

  // working registers
  logic [T-1:0]   now;
  logic [IV_W-1:0] iv;
  logic [T-1:0]   quo;
  logic [IV_W-1:0] rem;
  logic [T-1:0]   tick;
  logic [63:0]    prod;
  logic [T-1:0]   acc;
  logic [65:0]    diff;
  logic           anch;

  logic [T-1:0]   ts_in;
  logic [IV_W:0]  trial;
  logic [IV_W:0]  trial_sub;
  logic           trial_ge;
  logic           round_up;
  logic [T-1:0]   tick_fix;
  logic [63:0]    tick_w;
  logic [63:0]    prod_hi_sh;
  logic [ERR_W-1:0] err_sat;

  assign status.started = started;
  assign ts_in          = timestamp[T-1:0];

  assign trial     = {rem, quo[T-1]};
  assign trial_ge  = (trial >= {1'b0, iv});
  assign trial_sub = trial - {1'b0, iv};
  assign round_up  = ({rem, 1'b0} >= {1'b0, iv});
  assign tick_fix  = (tick <= prev_tick) ? (prev_tick + 1'b1) : tick;
  assign tick_w    = 64'(tick);
  assign prod_hi_sh = {prod[31:0], 32'd0};

  always_comb begin
    if (!diff[65] && (|diff[64:ERR_W-1])) begin
      err_sat = {1'b0, {(ERR_W-1){1'b1}}};
    end else if (diff[65] && !(&diff[64:ERR_W-1])) begin
      err_sat = {1'b1, {(ERR_W-1){1'b0}}};
    end else begin
      err_sat = diff[ERR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started   <= 1'b0;
      epoch     <= '0;
      prev_tick <= '0;
    end else if (cmd.capture && !started) begin
      started   <= 1'b1;
      epoch     <= ts_in;
      prev_tick <= '0;
    end else if (cmd.clamp) begin
      prev_tick <= tick_fix;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      now  <= ts_in;
      iv   <= (interval == '0) ? IV_W'(1) : interval;
      rem  <= '0;
      anch <= !started;
      // anchor word: pass through with tick and error of zero
      acc  <= ts_in;
      tick <= '0;
      diff <= '0;
      quo  <= (ts_in > epoch) ? (ts_in - epoch) : '0;
    end
    if (cmd.div_step) begin
      quo <= {quo[T-2:0], trial_ge};
      rem <= trial_ge ? trial_sub[IV_W-1:0] : trial[IV_W-1:0];
    end
    if (cmd.round) begin
      tick <= quo + T'(round_up);
    end
    if (cmd.clamp) begin
      tick <= tick_fix;
    end
    if (cmd.mul_lo) begin
      prod <= tick_w[31:0] * iv;
      acc  <= epoch;
    end
    if (cmd.add_lo) begin
      acc <= acc + prod[T-1:0];
    end
    if (cmd.mul_hi) begin
      prod <= tick_w[63:32] * iv;
    end
    if (cmd.add_hi) begin
      acc <= acc + prod_hi_sh[T-1:0];
    end
    if (cmd.err_sub) begin
      diff <= {2'b00, 64'(acc)} - {2'b00, 64'(now)};
    end
    if (cmd.load_out) begin
      present_out  <= 64'(acc);
      tick_out     <= 64'(tick);
      error_out    <= err_sat;
      anchored_out <= anch;
    end
  end

endmodule

### sv/vsync_grid_timestamp_quantizer_core.sv
// ----------------------------------------------------------------------------
// vsync_grid_timestamp_quantizer_core
// Snaps nanosecond timestamps onto a refresh grid set by an APB register.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis carries one 64-bit timestamp per word. Output stream
//   m_axis returns one word per input: quantized time, tick index and the
//   saturated signed error in tdata, and the anchor flag in tuser.
//   The APB port holds the grid period at byte address 0; write it only
//   while the block is idle. A zero interval acts as one.
// Sequence:
//   The first word after reset sets the epoch, bypasses the arithmetic and
//   waits in the hold state until it loads the output register. Every later
//   word runs a one-bit-per-cycle restoring divider, which dominates, then
//   round, clamp, two 32x32 multiply-add steps and error subtraction.
//   s_axis_tready returns high the cycle after the result is loaded, so a
//   new word is taken only once the last one has reached the output register.
// Reset and stall:
//   Reset clears the epoch, the last tick and the output valid, and reloads
//   the 120 Hz interval. The result waits in its register while m_axis is
//   stalled; the next word is accepted and computed meanwhile, and holds
//   before loading until the output register frees up.
// ----------------------------------------------------------------------------
module vsync_grid_timestamp_quantizer_core import vgtq_pkg::*; #(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // APB configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [TS_W-1:0]       s_axis_tdata,   // [63:0] timestamp_ns
  // output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [63:0] present_ns,
                                                // [127:64] tick_index,
                                                // [175:128] error_ns
  output logic                  m_axis_tuser    // [0] anchored
);

  logic [IV_W-1:0]  grid_period;
  vgtq_cmd_t        cmd;
  vgtq_status_t     status;
  logic [TS_W-1:0]  present_ns;
  logic [TS_W-1:0]  tick_index;
  logic [ERR_W-1:0] error_ns;
  logic             cfg_wr;

  // Register write completes in the access phase; pready is tied high.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_INTERVAL) ? grid_period : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_period <= INTERVAL_RESET;
    end else if (cfg_wr && (paddr[2] == REG_INTERVAL)) begin
      grid_period <= pwdata;
    end
  end

  vgtq_ctrl #(
    .TIME_BITS (TIME_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  vgtq_dp #(
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .interval     (grid_period),
    .timestamp    (s_axis_tdata),
    .present_out  (present_ns),
    .tick_out     (tick_index),
    .error_out    (error_ns),
    .anchored_out (m_axis_tuser)
  );

  // Pack output fields, highest field first.
  assign m_axis_tdata = {error_ns, tick_index, present_ns};

endmodule

### sv/vgtq_checker.sv
// ----------------------------------------------------------------------------
// vgtq_checker
// Port-level checks of the quantizer, bound onto the top level.
// ----------------------------------------------------------------------------
module vgtq_checker import vgtq_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tuser
);

  // Reset leaves the block ready and the output empty.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (s_axis_tready && !m_axis_tvalid))
    else $error("block not idle after reset");

  // One word at a time: ready drops after each accepted input.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while a word is in flight");

  // Anchor word carries tick zero and error zero.
  a_anchor_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |->
      (m_axis_tdata[127:64] == 64'd0 && m_axis_tdata[175:128] == 48'd0))
    else $error("anchor word with nonzero tick or error");

  // Stalled output holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("output changed while stalled");

endmodule

bind vsync_grid_timestamp_quantizer_core vgtq_checker u_vgtq_checker (.*);

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the vsync grid timestamp quantizer core.
// Streams timestamps in, predicts each quantized word in the bench and
// compares it field by field on the output stream. Directed words cover the
// anchor, rounding at half a period, time before the epoch, saturation of
// the error both ways, wrap of present time and of the tick, and the zero
// interval. Random frame streams then run under several grid intervals with
// random gaps and stalls on both streams; one interval runs without them.
// ----------------------------------------------------------------------------
module tb;
  import vgtq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Overall cycle budget; a correct run needs a small fraction of it.
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  // Receiver hold-off long enough to fill the core and stall its input.
  localparam int unsigned HOLD_CYCLES = 600;
  // Tail after the last word, a bit above one full computation.
  localparam int unsigned TAIL_CYCLES = TIME_BITS_DEF + 16;

  localparam logic [ADDR_W-1:0] INTERVAL_ADDR = ADDR_W'({REG_INTERVAL, 2'b00});
  localparam logic [TS_W-1:0]   ERR_POS_LIMIT = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [TS_W-1:0]   ERR_NEG_LIMIT = 64'h0000_8000_0000_0000;
  localparam logic [TS_W-1:0]   EPOCH_STAMP   = 64'd5;
  localparam logic [TS_W-1:0]   ALL_ONES      = '1;

  // One output word, unpacked.
  typedef struct packed {
    logic [TS_W-1:0]  present;
    logic [TS_W-1:0]  tick;
    logic [ERR_W-1:0] err;
    logic             anchored;
  } grid_word_t;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [ADDR_W-1:0]     paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [TS_W-1:0]       s_axis_tdata;   // [63:0] timestamp_ns
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;   // [63:0] present_ns, [127:64] tick_index,
                                         // [175:128] error_ns
  logic                  m_axis_tuser;   // [0] anchored

  // Bench copy of the core state and its register.
  logic [IV_W-1:0] interval_q;
  logic            anchored_q;
  logic [TS_W-1:0] epoch_q;
  logic [TS_W-1:0] last_tick_q;
  logic [TS_W-1:0] last_stamp;

  grid_word_t  snaps_due[$];      // quantized words still owed by the core
  int unsigned fault_count;
  int unsigned cycle_count;
  logic        idle_off;          // no gaps or stalls on either stream
  logic        hold_req;          // ask the receiver for one long hold-off

  vsync_grid_timestamp_quantizer_core dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop on a hang.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Snap one timestamp onto the grid and advance the bench state.
  function automatic grid_word_t snap_to_grid(input logic [TS_W-1:0] now);
    logic [TS_W-1:0] iv;
    logic [TS_W-1:0] elapsed;
    logic [TS_W-1:0] quo;
    logic [TS_W-1:0] rem;
    logic [TS_W-1:0] tick;
    logic [TS_W-1:0] diff;
    grid_word_t      w;
    // A zero interval acts as one.
    iv = (interval_q == '0) ? 64'd1 : {32'd0, interval_q};
    // First word after reset: pin the epoch and pass the time through.
    if (!anchored_q) begin
      anchored_q  = 1'b1;
      epoch_q     = now;
      last_tick_q = '0;
      w.present   = now;
      w.tick      = '0;
      w.err       = '0;
      w.anchored  = 1'b1;
      return w;
    end
    // Clamp time before the epoch to zero elapsed.
    elapsed = (now > epoch_q) ? now - epoch_q : '0;
    quo     = elapsed / iv;
    rem     = elapsed % iv;
    // Round to nearest, an exact half goes up.
    tick = quo + ((rem >= iv - iv / 2) ? 64'd1 : 64'd0);
    // Force strictly increasing ticks; all ones wraps to zero.
    if (tick <= last_tick_q)
      tick = last_tick_q + 64'd1;
    last_tick_q = tick;
    w.present   = epoch_q + tick * iv;
    w.tick      = tick;
    w.anchored  = 1'b0;
    // Exact signed difference, saturated to the error width.
    if (w.present >= now) begin
      diff  = w.present - now;
      w.err = (diff > ERR_POS_LIMIT) ? ERR_POS_LIMIT[ERR_W-1:0] : diff[ERR_W-1:0];
    end else begin
      diff = now - w.present;
      if (diff > ERR_NEG_LIMIT)
        diff = ERR_NEG_LIMIT;
      diff  = 64'd0 - diff;
      w.err = diff[ERR_W-1:0];
    end
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Idle length: mostly short, a few long.
  function automatic int unsigned gap_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 80)
      return $urandom_range(1, 3);
    if (pick < 97)
      return $urandom_range(4, 20);
    return $urandom_range(40, 150);
  endfunction

  // Next timestamp: mostly a frame near the next grid ticks, some noise.
  function automatic logic [TS_W-1:0] pick_timestamp();
    logic [TS_W-1:0] iv;
    logic [TS_W-1:0] offset;
    logic [TS_W-1:0] step;
    int unsigned     pick;
    iv   = (interval_q == '0) ? 64'd1 : {32'd0, interval_q};
    pick = $urandom_range(0, 99);
    // Noise: any time at all, a step back in time, a repeated frame.
    if (pick < 5)
      return {$urandom, $urandom};
    if (pick < 10)
      return last_stamp - {32'($urandom_range(0, 3)), $urandom};
    if (pick < 14)
      return last_stamp;
    // Frame: next tick mostly, sometimes a dropped frame or a late one.
    pick = $urandom_range(0, 99);
    step = (pick < 70) ? 64'd1 : (pick < 90) ? 64'd2 : (pick < 95) ? 64'd3 : 64'd0;
    // Land right on the rounding boundary now and then.
    pick = $urandom_range(0, 19);
    if (pick == 0)
      offset = iv - iv / 2;
    else if (pick == 1)
      offset = iv - iv / 2 - 64'd1;
    else
      offset = 64'($urandom_range(0, 32'(iv - 64'd1)));
    return epoch_q + (last_tick_q + step) * iv + offset;
  endfunction

  task automatic note_fault(input string what);
    fault_count++;
    if (fault_count <= 10)
      $display("mismatch: %s", what);
  endtask

  // Offer one word, hold it until taken, then record what it must produce.
  task automatic send_stamp(input logic [TS_W-1:0] stamp);
    int unsigned gap;
    gap = (idle_off || $urandom_range(0, 1) == 0) ? 0 : gap_len();
    @(negedge clk);
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = stamp;
    do @(posedge clk); while (!s_axis_tready);
    snaps_due.push_back(snap_to_grid(stamp));
    last_stamp = stamp;
  endtask

  // Drop valid and wait for every owed word.
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (snaps_due.size() != 0)
      @(posedge clk);
  endtask

  // One APB transfer: setup cycle, then access cycle until pready.
  task automatic apb_access(input logic is_write, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = is_write;
    paddr   = INTERVAL_ADDR;
    pwdata  = wdata;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Change the grid interval while the core is idle, then read it back.
  task automatic set_interval(input logic [IV_W-1:0] value);
    logic [31:0] rd;
    drain();
    apb_access(1'b1, value, rd);
    interval_q = value;
    apb_access(1'b0, 32'd0, rd);
    if (rd !== value)
      note_fault($sformatf("interval readback expected %h got %h", value, rd));
  endtask

  // --------------------------------------------------------------------------
  // Output checking
  // --------------------------------------------------------------------------

  always @(posedge clk) begin
    grid_word_t got;
    grid_word_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.present  = m_axis_tdata[TS_W-1:0];
      got.tick     = m_axis_tdata[2*TS_W-1:TS_W];
      got.err      = m_axis_tdata[2*TS_W+ERR_W-1:2*TS_W];
      got.anchored = m_axis_tuser;
      if (snaps_due.size() == 0) begin
        note_fault($sformatf("unexpected word present %h tick %h err %h anchored %b",
                             got.present, got.tick, got.err, got.anchored));
      end else begin
        want = snaps_due.pop_front();
        if (got !== want)
          note_fault($sformatf({"present %h/%h tick %h/%h err %h/%h anchored %b/%b",
                                " (expected/actual)"},
                               want.present, got.present, want.tick, got.tick,
                               want.err, got.err, want.anchored, got.anchored));
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int unsigned stall;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req)
        stall = HOLD_CYCLES;
      else if (!idle_off && $urandom_range(0, 99) < 4)
        stall = gap_len();
      else
        stall = 0;
      hold_req = 1'b0;
      if (stall != 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready = 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  task automatic test_register_reset();
    logic [31:0] rd;
    apb_access(1'b0, 32'd0, rd);
    if (rd !== INTERVAL_RESET)
      note_fault($sformatf("reset interval expected %h got %h", INTERVAL_RESET, rd));
  endtask

  // Anchor, then rounding around half a period of the odd 120 Hz interval.
  task automatic test_anchor_and_rounding();
    logic [TS_W-1:0] iv;
    iv = {32'd0, INTERVAL_RESET};
    send_stamp(EPOCH_STAMP);                              // sets the epoch
    send_stamp(64'd0);                                    // time before the epoch
    send_stamp(EPOCH_STAMP + 10 * iv + iv / 2);           // just under half: down
    send_stamp(EPOCH_STAMP + 20 * iv + (iv - iv / 2));    // exact half: up
    send_stamp(EPOCH_STAMP + 30 * iv - 64'd1);
    send_stamp(EPOCH_STAMP + 30 * iv - 64'd1);            // repeat: forced tick
  endtask

  // Widest interval: both error saturations and a wrapped present time.
  task automatic test_wide_interval();
    set_interval('1);
    send_stamp(EPOCH_STAMP + 64'h0004_0000_0000_0000);
    send_stamp(64'd0);                                    // far ahead: clip high
    send_stamp(ALL_ONES);                                 // present wraps: clip low
  endtask

  // Unit interval: run the tick up to all ones and over into zero.
  task automatic test_tick_wrap();
    set_interval(32'd1);
    send_stamp(ALL_ONES);
    repeat (6) send_stamp(64'd1000);
  endtask

  // Zero acts as one; then one word under an even interval.
  task automatic test_degenerate_intervals();
    set_interval(32'd0);
    send_stamp(EPOCH_STAMP + 64'd100);
    set_interval(32'd2);
    send_stamp(EPOCH_STAMP + 64'd601);
  endtask

  // Hold the output long enough to stall the input, then pause the sender.
  task automatic test_backpressure();
    set_interval(INTERVAL_RESET);
    hold_req = 1'b1;
    repeat (8) send_stamp(pick_timestamp());
    drain();
    repeat (4) send_stamp(pick_timestamp());
  endtask

  // Random frame streams under a spread of intervals.
  task automatic test_random_frames();
    logic [IV_W-1:0] intervals[7];
    intervals[0] = INTERVAL_RESET;
    intervals[1] = 32'd1;
    intervals[2] = 32'd3;
    intervals[3] = '1;
    intervals[4] = $urandom;
    intervals[5] = 32'd1000;
    intervals[6] = 32'd0;
    for (int p = 0; p < 7; p++) begin
      set_interval(intervals[p]);
      idle_off = (p == 2);
      repeat (65) send_stamp(pick_timestamp());
    end
    idle_off = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    idle_off      = 1'b0;
    hold_req      = 1'b0;
    fault_count   = 0;
    interval_q    = INTERVAL_RESET;
    anchored_q    = 1'b0;
    epoch_q       = '0;
    last_tick_q   = '0;
    last_stamp    = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_register_reset();
    test_anchor_and_rounding();
    test_wide_interval();
    test_tick_wrap();
    test_degenerate_intervals();
    test_backpressure();
    test_random_frames();

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0 && snaps_due.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

### vsync_grid_timestamp_quantizer_core.f
sv/vgtq_pkg.sv
sv/vgtq_ctrl.sv
sv/vgtq_dp.sv
sv/vsync_grid_timestamp_quantizer_core.sv
sv/vgtq_checker.sv
dv/tb.sv
